@@ design/srhd_p2c_pkg.sv @@
// shared widths, types and constants of the primitive to conserved converter
package srhd_p2c_pkg;

	localparam int IN_BYTES  = 15;
	localparam int OUT_BYTES = 20;
	localparam int IN_W      = 8 * IN_BYTES;
	localparam int OUT_W     = 8 * OUT_BYTES;

	localparam int FACTOR_W  = 25;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 25'd163840;

	// quotient bits of 2^64/d and root bits of its square root
	localparam int DIV_STAGES  = 65;
	localparam int SQRT_STAGES = 33;

	localparam logic [47:0] ENTH_CAP = 48'hFFFF_FFFF_FFFF;

	// per-item values that ride along the divider and root stages
	typedef struct packed {
		logic [30:0]        rho;
		logic [30:0]        pres;
		logic [40:0]        w;
		logic signed [17:0] vx;
		logic signed [17:0] vy;
		logic signed [17:0] vz;
		logic               sup;
	} carry_t;

endpackage

@@ design/srhd_primitive_to_conserved_core.sv @@
// primitive to conserved converter for special-relativistic hydrodynamics cells
//
// usage
//  - input words on s_tvalid/s_tready/s_tdata: one cell's rest density and
//    pressure, both q15.16, and three velocity components, signed q1.16
//  - result words on m_tvalid/m_tready/m_tdata, with the superluminal flag on
//    m_tuser; a superluminal cell gives all-zero tdata
//  - gamma/(gamma-1) sits in a register written over cfg_valid/cfg_ready/
//    cfg_data; write it only while no cell is in flight
//  - throughput one cell per clock unless the output word is held; the
//    pipeline is two front stages (squares, enthalpy product, then speed sum),
//    65 restoring divider stages forming 2^64/(1-v^2), 33 root stages for the
//    lorentz factor and four back stages (products, sums, momenta, saturation)
//  - the pipeline moves as one; when the output word is held by the receiver
//    the whole pipeline freezes, bubbles included, and s_tready falls
//  - reset clears every stage valid and loads the enthalpy factor with 2.5
//  - no state is kept between cells
module srhd_primitive_to_conserved_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// rest_density[30:0], vel_x[48:31], vel_y[66:49], vel_z[84:67], pressure[115:85]
	input  logic [srhd_p2c_pkg::IN_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cons_density[30:0], mom_x[62:31], mom_y[94:63], mom_z[126:95],
	// energy_cons[158:127]
	output logic [srhd_p2c_pkg::OUT_W-1:0]    m_tdata,
	// superluminal[0]
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srhd_p2c_pkg::FACTOR_W-1:0] cfg_data
);

	localparam int ND = srhd_p2c_pkg::DIV_STAGES;
	localparam int NS = srhd_p2c_pkg::SQRT_STAGES;

	logic en;
	logic [srhd_p2c_pkg::FACTOR_W-1:0] factor_q;

	// global advance: move when the output slot is empty or being taken
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= srhd_p2c_pkg::FACTOR_RESET;
		end else if (cfg_valid) begin
			factor_q <= cfg_data;
		end
	end

	// stage 1: squares of the velocities and the enthalpy factor product
	logic               v_s1;
	logic [30:0]        rho_s1, pres_s1;
	logic signed [17:0] vx_s1, vy_s1, vz_s1;
	logic [34:0]        sqx_s1, sqy_s1, sqz_s1;
	logic [55:0]        kp_s1;
	logic signed [17:0] in_vx, in_vy, in_vz;
	logic signed [35:0] px, py, pz;

	assign in_vx = $signed(s_tdata[48:31]);
	assign in_vy = $signed(s_tdata[66:49]);
	assign in_vz = $signed(s_tdata[84:67]);
	assign px    = in_vx * in_vx;
	assign py    = in_vy * in_vy;
	assign pz    = in_vz * in_vz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s1  <= s_tdata[30:0];
			pres_s1 <= s_tdata[115:85];
			vx_s1   <= in_vx;
			vy_s1   <= in_vy;
			vz_s1   <= in_vz;
			sqx_s1  <= px[34:0];
			sqy_s1  <= py[34:0];
			sqz_s1  <= pz[34:0];
			kp_s1   <= factor_q * s_tdata[115:85];
		end
	end

	// stage 2: squared speed, denominator 1-v^2 and enthalpy density
	// these registers are slot 0 of the divider arrays
	logic                  div_v_s [0:ND];
	logic [32:0]           div_d_s [0:ND];
	logic [31:0]           div_r_s [0:ND];
	logic [64:0]           div_q_s [0:ND];
	srhd_p2c_pkg::carry_t  div_c_s [0:ND];

	logic [35:0] v2;
	logic        sup;
	srhd_p2c_pkg::carry_t c_in;

	assign v2  = {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
	assign sup = |v2[35:32];

	always_comb begin
		c_in.rho  = rho_s1;
		c_in.pres = pres_s1;
		c_in.w    = {10'd0, rho_s1} + {1'b0, kp_s1[55:16]};
		c_in.vx   = vx_s1;
		c_in.vy   = vy_s1;
		c_in.vz   = vz_s1;
		c_in.sup  = sup;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			div_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// a superluminal cell divides by one to keep the datapath defined
			div_d_s[0] <= sup ? 33'd1 : (33'h1_0000_0000 - {1'b0, v2[31:0]});
			div_r_s[0] <= '0;
			div_q_s[0] <= '0;
			div_c_s[0] <= c_in;
		end
	end

	// restoring divider: 2^64 / d, one quotient bit per stage, msb first
	genvar k;
	for (k = 0; k < ND; k++) begin : g_div
		localparam logic NBIT = (k == 0);
		logic [32:0] sh;
		logic        qb;

		assign sh = {div_r_s[k], NBIT};
		assign qb = (sh >= div_d_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (en) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_d_s[k+1] <= div_d_s[k];
				div_r_s[k+1] <= qb ? 32'(sh - div_d_s[k]) : sh[31:0];
				div_q_s[k+1] <= {div_q_s[k][63:0], qb};
				div_c_s[k+1] <= div_c_s[k];
			end
		end
	end

	// digit-by-digit square root of the quotient, two radicand bits per stage
	logic                  sq_v_s    [1:NS];
	logic [65:0]           sq_x_s    [1:NS];
	logic [34:0]           sq_rem_s  [1:NS];
	logic [32:0]           sq_root_s [1:NS];
	srhd_p2c_pkg::carry_t  sq_c_s    [1:NS];

	genvar j;
	for (j = 0; j < NS; j++) begin : g_sqrt
		logic                 iv;
		logic [65:0]          ix;
		logic [34:0]          irem;
		logic [32:0]          iroot;
		srhd_p2c_pkg::carry_t ic;
		logic [36:0]          rsh, trial;
		logic                 ge;

		if (j == 0) begin : g_first
			assign iv    = div_v_s[ND];
			assign ix    = {1'b0, div_q_s[ND]};
			assign irem  = '0;
			assign iroot = '0;
			assign ic    = div_c_s[ND];
		end else begin : g_next
			assign iv    = sq_v_s[j];
			assign ix    = sq_x_s[j];
			assign irem  = sq_rem_s[j];
			assign iroot = sq_root_s[j];
			assign ic    = sq_c_s[j];
		end

		assign rsh   = {irem, ix[65-2*j -: 2]};
		assign trial = {2'b00, iroot, 2'b01};
		assign ge    = (rsh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[j+1] <= iv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x_s[j+1]    <= ix;
				sq_rem_s[j+1]  <= ge ? 35'(rsh - trial) : rsh[34:0];
				sq_root_s[j+1] <= {iroot[31:0], ge};
				sq_c_s[j+1]    <= ic;
			end
		end
	end

	// back stage 1: partial products of w*W^2 and rho*W
	logic [32:0] lf;
	logic [48:0] lf2;
	srhd_p2c_pkg::carry_t cs;

	assign lf  = sq_root_s[NS];
	assign lf2 = sq_x_s[NS][64:16];
	assign cs  = sq_c_s[NS];

	logic                 v_s3;
	srhd_p2c_pkg::carry_t c_s3;
	logic [47:0]          pp0_s3;
	logic [48:0]          pp1_s3;
	logic [40:0]          pp2_s3;
	logic [41:0]          pp3_s3;
	logic [62:0]          dp_s3;
	logic                 dhi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3   <= cs;
			pp0_s3 <= cs.w[23:0]  * lf2[23:0];
			pp1_s3 <= cs.w[23:0]  * lf2[48:24];
			pp2_s3 <= cs.w[40:24] * lf2[23:0];
			pp3_s3 <= cs.w[40:24] * lf2[48:24];
			dp_s3  <= cs.rho * lf[31:0];
			// W is 2^32 exactly only when 1-v^2 is one lsb
			dhi_s3 <= lf[32];
		end
	end

	// back stage 2: energy term with its cap, conserved density, speeds
	logic [89:0] eprod;
	assign eprod = {42'd0, pp0_s3} + {17'd0, pp1_s3, 24'd0} + {25'd0, pp2_s3, 24'd0}
		+ {pp3_s3, 48'd0};

	logic                 v_s4;
	srhd_p2c_pkg::carry_t c_s4;
	logic [47:0]          e_s4, dens_s4;
	logic [17:0]          mx_s4, my_s4, mz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4    <= c_s3;
			e_s4    <= (|eprod[89:64]) ? srhd_p2c_pkg::ENTH_CAP : eprod[63:16];
			dens_s4 <= dhi_s3 ? {1'b0, c_s3.rho, 16'd0} : {1'b0, dp_s3[62:16]};
			mx_s4   <= c_s3.vx[17] ? 18'(-c_s3.vx) : c_s3.vx;
			my_s4   <= c_s3.vy[17] ? 18'(-c_s3.vy) : c_s3.vy;
			mz_s4   <= c_s3.vz[17] ? 18'(-c_s3.vz) : c_s3.vz;
		end
	end

	// back stage 3: momentum magnitudes and energy difference
	logic               v_s5, sup_s5, nx_s5, ny_s5, nz_s5;
	logic [65:0]        sx_s5, sy_s5, sz_s5;
	logic signed [49:0] tau_s5;
	logic [47:0]        dens_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sup_s5  <= c_s4.sup;
			nx_s5   <= c_s4.vx[17];
			ny_s5   <= c_s4.vy[17];
			nz_s5   <= c_s4.vz[17];
			sx_s5   <= e_s4 * mx_s4;
			sy_s5   <= e_s4 * my_s4;
			sz_s5   <= e_s4 * mz_s4;
			tau_s5  <= $signed({2'b00, e_s4}) - $signed({19'd0, c_s4.pres})
				- $signed({2'b00, dens_s4});
			dens_s5 <= dens_s4;
		end
	end

	// back stage 4: saturation into the output register
	function automatic logic [31:0] sat_mom(input logic [65:0] prod, input logic neg);
		logic [49:0] m;
		logic        big;
		m   = prod[65:16];
		big = |m[49:31];
		if (neg) begin
			sat_mom = big ? 32'h8000_0000 : 32'(-m[31:0]);
		end else begin
			sat_mom = big ? 32'h7FFF_FFFF : m[31:0];
		end
	endfunction

	logic [31:0] tau_sat;
	logic [30:0] dens_sat;

	assign tau_sat  = (tau_s5[49:31] == '0 || tau_s5[49:31] == '1) ? tau_s5[31:0] :
		(tau_s5[49] ? 32'h8000_0000 : 32'h7FFF_FFFF);
	assign dens_sat = (|dens_s5[47:31]) ? 31'h7FFF_FFFF : dens_s5[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= sup_s5;
			if (sup_s5) begin
				m_tdata <= '0;
			end else begin
				m_tdata <= {1'b0, tau_sat, sat_mom(sz_s5, nz_s5), sat_mom(sy_s5, ny_s5),
					sat_mom(sx_s5, nx_s5), dens_sat};
			end
		end
	end

	// checks
	a_sup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("superluminal word carries data");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while the output word is held");

	a_factor: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(factor_q))
		else $error("enthalpy factor changed without a write");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[srhd_p2c_pkg::OUT_W-1])
		else $error("pad bit of the output word set");

endmodule

@@ tb/sv/srhd_p2c_checker.sv @@
// result predictor and scoreboard for the primitive to conserved converter
`timescale 1ns / 100ps

module srhd_p2c_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [srhd_p2c_pkg::IN_W-1:0]     s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [srhd_p2c_pkg::OUT_W-1:0]    m_tdata,
	input  logic                              m_tuser,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [srhd_p2c_pkg::FACTOR_W-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending
);

	typedef struct packed {
		logic        superluminal;
		logic [31:0] energy_cons;
		logic [31:0] mom_z;
		logic [31:0] mom_y;
		logic [31:0] mom_x;
		logic [30:0] cons_density;
	} cons_word_t;

	logic [srhd_p2c_pkg::FACTOR_W-1:0] factor;
	cons_word_t                        cons_q[$];
	int                                mismatches;

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -128'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// truncated toward zero, magnitude capped well past saturation
	function automatic logic [31:0] momentum_of(logic [63:0] e, logic signed [17:0] v);
		logic [127:0] m;
		logic [17:0]  mag;
		mag = v < 0 ? -v : v;
		m = ({64'd0, e} * mag) >> 16;
		if (m > (128'd1 << 40)) m = 128'd1 << 40;
		return clamp32(v < 0 ? -$signed(m) : $signed(m));
	endfunction

	function automatic cons_word_t convert_cell(logic [srhd_p2c_pkg::IN_W-1:0] d);
		cons_word_t         r;
		logic [30:0]        rho, pres;
		logic signed [17:0] vx, vy, vz;
		logic [63:0]        v2, dn, lf, lf2, q, w, dens, e;
		logic [127:0]       prod;
		rho  = d[30:0];
		vx   = d[48:31];
		vy   = d[66:49];
		vz   = d[84:67];
		pres = d[115:85];
		r = '0;
		v2 = 64'(36'(vx) * 36'(vx)) + 64'(36'(vy) * 36'(vy)) + 64'(36'(vz) * 36'(vz));
		if (v2 >= (64'd1 << 32)) begin
			r.superluminal = 1'b1;
			return r;
		end
		dn = (64'd1 << 32) - v2;
		// 2^64 / d, computed exactly at 65 bits
		q = 64'(({1'b1, 64'd0}) / {1'b0, dn});
		lf = dn == 1 ? 64'd1 << 32 : int_sqrt(q);
		lf2 = (64'd1 << 48) / dn;
		w = rho + ((64'(factor) * pres) >> 16);
		dens = (64'(rho) * lf) >> 16;
		prod = ({64'd0, w} * lf2) >> 16;
		e = prod > 128'(srhd_p2c_pkg::ENTH_CAP) ? 64'(srhd_p2c_pkg::ENTH_CAP) : prod[63:0];
		r.cons_density = dens > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : dens[30:0];
		r.mom_x = momentum_of(e, vx);
		r.mom_y = momentum_of(e, vy);
		r.mom_z = momentum_of(e, vz);
		r.energy_cons = clamp32($signed({64'd0, e}) - $signed({97'd0, pres})
			- $signed({64'd0, dens}));
		return r;
	endfunction

	assign pending = cons_q.size();

	always @(posedge clk or negedge arst_n) begin
		cons_word_t exp_w, got;
		if (!arst_n) begin
			factor <= srhd_p2c_pkg::FACTOR_RESET;
			cons_q.delete();
			fail_count <= 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) factor <= cfg_data;
			if (s_tvalid && s_tready) cons_q.push_back(convert_cell(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[158:0]};
				if (cons_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (mismatches < 10) $display("unexpected word %h", got);
					mismatches++;
				end else begin
					exp_w = cons_q.pop_front();
					if (got !== exp_w || m_tdata[srhd_p2c_pkg::OUT_W-1:159] !== '0) begin
						fail_count <= fail_count + 1;
						if (mismatches < 10)
							$display("mismatch dens %h/%h mx %h/%h my %h/%h mz %h/%h tau %h/%h sl %b/%b",
								exp_w.cons_density, got.cons_density, exp_w.mom_x, got.mom_x,
								exp_w.mom_y, got.mom_y, exp_w.mom_z, got.mom_z,
								exp_w.energy_cons, got.energy_cons,
								exp_w.superluminal, got.superluminal);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// stimulus and verdict for the primitive to conserved converter
`timescale 1ns / 100ps

module tb_top;

	localparam int LATENCY = 104;

	// idling phases
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid, s_tready;
	logic [srhd_p2c_pkg::IN_W-1:0]     s_tdata;
	logic                              m_tvalid, m_tready;
	logic [srhd_p2c_pkg::OUT_W-1:0]    m_tdata;
	logic                              m_tuser;
	logic                              cfg_valid, cfg_ready;
	logic [srhd_p2c_pkg::FACTOR_W-1:0] cfg_data;
	int                                fail_count, pending;
	idle_mode_t                        idle_mode;
	bit                                hold_off;

	srhd_primitive_to_conserved_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	srhd_p2c_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on the whole run
	initial begin
		#3000000;
		$display("tb_top NOT OK");
		$finish;
	end

	// receiver: random stalls by phase, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				m_tready <= 1'b0;
			else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
				m_tready <= $urandom_range(99) >= (idle_mode == IDLE_RECV ? 85 : 21);
			else
				m_tready <= 1'b1;
		end
	end

	// pack one cell; velocity given as 18 bit two's complement
	function automatic logic [srhd_p2c_pkg::IN_W-1:0] pack_cell(logic [30:0] rho,
		logic [17:0] vx, logic [17:0] vy, logic [17:0] vz, logic [30:0] pres);
		logic [srhd_p2c_pkg::IN_W-1:0] d;
		d = '0;
		d[30:0] = rho;
		d[48:31] = vx;
		d[66:49] = vy;
		d[84:67] = vz;
		d[115:85] = pres;
		return d;
	endfunction

	// velocity mostly in the physical range, sometimes anywhere in the field
	function automatic logic [17:0] rand_vel();
		case ($urandom_range(9))
			0: return 18'($urandom);
			1: return $urandom_range(1) ? 18'd65535 : -18'sd65535;
			2: return 18'($signed($urandom_range(2000)) - 1000);
			default: return 18'($signed($urandom_range(75000)) - 37500);
		endcase
	endfunction

	function automatic logic [30:0] rand_q16();
		case ($urandom_range(3))
			0: return 31'($urandom);
			1: return 31'($urandom_range(1 << 20));
			2: return 31'($urandom_range(1 << 24));
			default: return 31'($urandom_range(1 << 17));
		endcase
	endfunction

	task automatic send_word(logic [srhd_p2c_pkg::IN_W-1:0] d);
		if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
			while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 85 : 21)) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_factor(logic [srhd_p2c_pkg::FACTOR_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [srhd_p2c_pkg::FACTOR_W-1:0] factors[6];
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_mode = IDLE_NONE;
		hold_off = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, rest, near-light, exactly light, superluminal fields
		send_word(pack_cell(0, 0, 0, 0, 0));
		send_word(pack_cell('1, 0, 0, 0, '1));
		send_word(pack_cell(31'd65536, 18'd32768, 0, 0, 31'd65536));
		send_word(pack_cell(31'd65536, 18'd65535, 0, 0, 31'd65536));
		send_word(pack_cell('1, 18'd65535, 0, 0, '1));
		send_word(pack_cell(31'd65536, -18'sd65535, 0, 0, 31'd100));
		send_word(pack_cell(31'd65536, 0, -18'sd65535, 0, 31'd100));
		send_word(pack_cell(31'd65536, 0, 0, -18'sd65535, 31'd100));
		send_word(pack_cell(31'd65536, 18'd65536, 0, 0, 31'd65536));
		send_word(pack_cell(31'd65536, -18'sd65536, 0, 0, 31'd65536));
		send_word(pack_cell(31'd65536, 18'd40000, 18'd40000, 18'd40000, 31'd5));
		send_word(pack_cell(31'd65536, 18'h1FFFF, 18'h20000, 18'h20000, 31'd5));
		send_word(pack_cell(31'd65536, 18'd37837, -18'sd37837, 18'd37837, '1));
		send_word(pack_cell(31'd1, 18'd1, -18'sd1, 18'd1, 31'd1));
		send_word(pack_cell('1, -18'sd30000, 18'd30000, -18'sd30000, '1));
		drain();

		// phased random run over several factor settings, extremes included
		factors = '{25'd65537, 25'd16777216, 25'd163840, 25'h1FFFFFF, 25'd0, 25'd98304};
		for (int ph = 0; ph < 6; ph++) begin
			write_factor(factors[ph]);
			for (int m = 0; m < 4; m++) begin
				idle_mode = idle_mode_t'(m);
				for (int i = 0; i < 37; i++)
					send_word(pack_cell(rand_q16(), rand_vel(), rand_vel(), rand_vel(),
						rand_q16()));
				if (ph == 1 && m == 0) begin
					// long receiver hold-off while the sender keeps offering words
					hold_off = 1'b1;
					fork
						begin
							repeat (400) @(posedge clk);
							hold_off = 1'b0;
						end
						for (int i = 0; i < 160; i++)
							send_word(pack_cell(rand_q16(), rand_vel(), rand_vel(),
								rand_vel(), rand_q16()));
					join
				end
				if (m == 1) begin
					// sender pauses until every result is back
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
